### hdl/jpeg_app_segment_stripper_core_defines.svh
// Assertion macros shared by the stripper RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef JPEG_APP_SEGMENT_STRIPPER_CORE_DEFINES_SVH
`define JPEG_APP_SEGMENT_STRIPPER_CORE_DEFINES_SVH

// same-cycle implication
`define JASS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JASS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/jass_pkg.sv
// Types and constants for the JPEG APPn segment stripper.
// No dependencies; imported by jass_parse and the top level.
package jass_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] SOI_CODE      = 8'hD8;
    localparam logic [7:0] APP0_CODE     = 8'hE0;
    localparam logic [7:0] APP1_CODE     = 8'hE1;
    localparam logic [7:0] APP15_CODE    = 8'hEF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_flag;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       stream_done;
        logic       run_last;
    } out_t;

    typedef struct packed {
        out_t [MAX_RESULTS-1:0] items;
        logic [CNT_W-1:0]       count;
    } res_bundle_t;

endpackage

### hdl/jpeg_app_segment_stripper_core.sv
// Top level of the JPEG APPn segment stripper: parser plus result queue.
// Depends on jass_pkg, jass_parse and the shared assertion macros.
//
// Usage:
//   s_valid/s_ready/s_item carry one raw stream byte per item with an end
//   flag on the final byte. m_valid/m_ready/m_item carry the filtered
//   stream; has_byte 0 marks an end-only item, stream_done flags the last
//   item of a stream, run_last the last item caused by one input item.
//   The first result of an input item is registered into m_item, or
//   queued behind it while the output is stalled. One input item per
//   cycle is sustained while each yields at most one result and the
//   receiver is ready; one releasing held header bytes yields up to five.
//   s_ready is low only while the pending queue behind the output
//   register is non-empty; a stalled receiver stops intake after one more
//   item with results. Items that yield nothing (held header bytes,
//   dropped payload) are still taken and leave the output untouched.
//   Reset (aresetn low, synchronous) empties the output and queue and
//   returns the parser to waiting for a start of image. After the end
//   flag the parser restarts by itself for the next stream.
`include "jpeg_app_segment_stripper_core_defines.svh"

module jpeg_app_segment_stripper_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  jass_pkg::in_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output jass_pkg::out_t m_item
);
    import jass_pkg::*;

    res_bundle_t            res;
    logic                   accept;
    logic                   load_out;

    out_t [MAX_RESULTS-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0]       pend_cnt_reg, pend_cnt_next;
    out_t                   out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;

    assign s_ready  = (pend_cnt_reg == '0);
    assign accept   = s_valid && s_ready;
    assign load_out = !m_valid_reg || m_ready;

    jass_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_item),
        .res     (res)
    );

    always_comb begin
        pend_next     = pend_reg;
        pend_cnt_next = pend_cnt_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        if (accept) begin
            if (load_out) begin
                if (res.count != '0) begin
                    out_next     = res.items[0];
                    m_valid_next = 1'b1;
                    for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                        pend_next[i] = res.items[i + 1];
                    end
                    pend_cnt_next = res.count - CNT_W'(1);
                end else begin
                    m_valid_next = 1'b0;
                end
            end else begin
                pend_next     = res.items;
                pend_cnt_next = res.count;
            end
        end else if (load_out) begin
            if (pend_cnt_reg != '0) begin
                out_next     = pend_reg[0];
                m_valid_next = 1'b1;
                for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                    pend_next[i] = pend_reg[i + 1];
                end
                pend_cnt_next = pend_cnt_reg - CNT_W'(1);
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            pend_cnt_reg <= pend_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    `JASS_ASSERT_IMPL(a_queue_behind_output, aclk, aresetn, pend_cnt_reg != '0, m_valid_reg, "pending items with empty output register")
    `JASS_ASSERT_NEXT(a_end_gives_item, aclk, aresetn, s_valid && s_ready && s_item.end_flag, m_valid_reg, "end of stream produced no output item")

endmodule

### hdl/jass_parse.sv
// Header parser of the stripper: parse state and the result list of one item.
// Depends on jass_pkg and the shared assertion macros.
`include "jpeg_app_segment_stripper_core_defines.svh"

module jass_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  jass_pkg::in_t        item,
    output jass_pkg::res_bundle_t res
);
    import jass_pkg::*;

    typedef enum logic [2:0] {
        PH_SOI0, PH_SOI1, PH_BODY, PH_MARK, PH_LENH, PH_LENL, PH_DECIDE, PH_PASS
    } phase_t;

    phase_t      phase_reg, phase_next, phase_upd;
    logic [7:0]  held_marker_reg, held_marker_next, held_marker_upd;
    logic [7:0]  held_len_high_reg, held_len_high_next, held_len_high_upd;
    logic [7:0]  held_len_low_reg, held_len_low_next, held_len_low_upd;
    logic [2:0]  held_count_reg, held_count_next, held_count_upd;
    logic [15:0] payload_left_reg, payload_left_next, payload_left_upd;
    logic        dropping_reg, dropping_next, dropping_upd;

    logic [2:0]  pre_cnt;
    logic [2:0]  post_cnt;
    logic        put_b;
    logic        body_en;
    logic [7:0]  b;
    logic [7:0]  seq [4];
    logic [3:0]  total;
    logic [CNT_W-1:0] n;

    assign b = item.in_byte;

    always_comb begin
        phase_upd         = phase_reg;
        held_marker_upd   = held_marker_reg;
        held_len_high_upd = held_len_high_reg;
        held_len_low_upd  = held_len_low_reg;
        held_count_upd    = held_count_reg;
        payload_left_upd  = payload_left_reg;
        dropping_upd      = dropping_reg;
        pre_cnt           = 3'd0;
        put_b             = 1'b0;
        body_en           = 1'b0;

        case (phase_reg)
            PH_SOI0: begin
                if (b == MARKER_PREFIX) begin
                    held_count_upd = 3'd1;
                    phase_upd      = PH_SOI1;
                end else begin
                    put_b     = 1'b1;
                    phase_upd = PH_PASS;
                end
            end
            PH_SOI1: begin
                pre_cnt        = 3'd1;
                put_b          = 1'b1;
                held_count_upd = 3'd0;
                if (b == SOI_CODE) begin
                    phase_upd        = PH_BODY;
                    payload_left_upd = 16'd0;
                    dropping_upd     = 1'b0;
                end else begin
                    phase_upd = PH_PASS;
                end
            end
            PH_BODY: begin
                body_en = 1'b1;
            end
            PH_MARK: begin
                if (b inside {[APP0_CODE:APP15_CODE]}) begin
                    held_marker_upd = b;
                    held_count_upd  = 3'd2;
                    phase_upd       = PH_LENH;
                end else begin
                    pre_cnt        = 3'd1;
                    put_b          = 1'b1;
                    held_count_upd = 3'd0;
                    phase_upd      = PH_PASS;
                end
            end
            PH_LENH: begin
                held_len_high_upd = b;
                held_count_upd    = 3'd3;
                phase_upd         = PH_LENL;
            end
            PH_LENL: begin
                held_len_low_upd = b;
                held_count_upd   = 3'd4;
                if ({held_len_high_reg, b} < 16'd2) begin
                    pre_cnt        = 3'd4;
                    held_count_upd = 3'd0;
                    phase_upd      = PH_PASS;
                end else begin
                    phase_upd = PH_DECIDE;
                end
            end
            PH_DECIDE: begin
                if (held_marker_reg == APP0_CODE) begin
                    pre_cnt      = 3'd4;
                    dropping_upd = 1'b0;
                end else begin
                    dropping_upd = 1'b1;
                end
                held_count_upd   = 3'd0;
                payload_left_upd = {held_len_high_reg, held_len_low_reg} - 16'd2;
                phase_upd        = PH_BODY;
                body_en          = 1'b1;
            end
            PH_PASS: begin
                put_b = 1'b1;
            end
            default: begin
                put_b     = 1'b1;
                phase_upd = PH_PASS;
            end
        endcase

        if (body_en) begin
            if (payload_left_upd != 16'd0) begin
                payload_left_upd = payload_left_upd - 16'd1;
                put_b            = !dropping_upd;
            end else if (b == MARKER_PREFIX) begin
                held_count_upd = 3'd1;
                phase_upd      = PH_MARK;
            end else begin
                put_b     = 1'b1;
                phase_upd = PH_PASS;
            end
        end
    end

    // end of stream releases what is still held, then back to reset state
    assign post_cnt = item.end_flag ? held_count_upd : 3'd0;

    assign seq[0] = MARKER_PREFIX;
    assign seq[1] = held_marker_upd;
    assign seq[2] = held_len_high_upd;
    assign seq[3] = held_len_low_upd;

    assign total = {1'b0, pre_cnt} + {3'b000, put_b} + {1'b0, post_cnt};

    always_comb begin
        int k;
        k   = 0;
        res = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            k = i - int'(pre_cnt) - int'(put_b);
            if (i < int'(pre_cnt)) begin
                res.items[i].out_byte = seq[2'(i)];
                res.items[i].has_byte = 1'b1;
            end else if ((i == int'(pre_cnt)) && put_b) begin
                res.items[i].out_byte = b;
                res.items[i].has_byte = 1'b1;
            end else if (k < int'(post_cnt)) begin
                res.items[i].out_byte = seq[2'(k)];
                res.items[i].has_byte = 1'b1;
            end
        end
        n = CNT_W'(total);
        if (item.end_flag && (n == '0)) begin
            n = CNT_W'(1);
        end
        if (n != '0) begin
            res.items[n - CNT_W'(1)].run_last    = 1'b1;
            res.items[n - CNT_W'(1)].stream_done = item.end_flag;
        end
        res.count = n;
    end

    always_comb begin
        phase_next         = phase_reg;
        held_marker_next   = held_marker_reg;
        held_len_high_next = held_len_high_reg;
        held_len_low_next  = held_len_low_reg;
        held_count_next    = held_count_reg;
        payload_left_next  = payload_left_reg;
        dropping_next      = dropping_reg;
        if (accept) begin
            if (item.end_flag) begin
                phase_next         = PH_SOI0;
                held_marker_next   = 8'd0;
                held_len_high_next = 8'd0;
                held_len_low_next  = 8'd0;
                held_count_next    = 3'd0;
                payload_left_next  = 16'd0;
                dropping_next      = 1'b0;
            end else begin
                phase_next         = phase_upd;
                held_marker_next   = held_marker_upd;
                held_len_high_next = held_len_high_upd;
                held_len_low_next  = held_len_low_upd;
                held_count_next    = held_count_upd;
                payload_left_next  = payload_left_upd;
                dropping_next      = dropping_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_SOI0;
            held_marker_reg   <= 8'd0;
            held_len_high_reg <= 8'd0;
            held_len_low_reg  <= 8'd0;
            held_count_reg    <= 3'd0;
            payload_left_reg  <= 16'd0;
            dropping_reg      <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            held_marker_reg   <= held_marker_next;
            held_len_high_reg <= held_len_high_next;
            held_len_low_reg  <= held_len_low_next;
            held_count_reg    <= held_count_next;
            payload_left_reg  <= payload_left_next;
            dropping_reg      <= dropping_next;
        end
    end

    `JASS_ASSERT_NEXT(a_end_resets, aclk, aresetn, accept && item.end_flag, (phase_reg == PH_SOI0) && (held_count_reg == 3'd0), "parser not back at start after end of stream")
    `JASS_ASSERT_IMPL(a_lenh_held, aclk, aresetn, phase_reg == PH_LENH, held_count_reg == 3'd2, "held count wrong while awaiting length")

endmodule

### tb/tb_top.sv
// Testbench for jpeg_app_segment_stripper_core: byte streams in, filtered stream out.
// Depends on jass_pkg; predicts each result item and checks it against the output.
`timescale 1ns / 100ps

module tb_top;
    import jass_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PERCENT = 27;
    localparam int ITEM_COUNT   = 300;
    localparam logic [7:0] DHT_CODE = 8'hC4;
    localparam logic [7:0] SOS_CODE = 8'hDA;

    typedef enum logic [2:0] {
        PH_SOI0, PH_SOI1, PH_BODY, PH_MARK, PH_LENH, PH_LENL, PH_DECIDE, PH_PASS
    } strip_phase_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_item  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_item;

    jpeg_app_segment_stripper_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // parser state mirror
    strip_phase_t strip_phase = PH_SOI0;
    logic [7:0]   hdr_code    = '0;
    logic [7:0]   hdr_len_hi  = '0;
    logic [7:0]   hdr_len_lo  = '0;
    logic [2:0]   hdr_count   = '0;
    logic [15:0]  skip_left   = '0;
    logic         skip_drop   = 1'b0;

    out_t       step_bytes[$];
    out_t       awaited_bytes[$];
    logic [7:0] stream_buf[$];

    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int fail_count   = 0;
    int bytes_sent   = 0;
    int cycle_count  = 0;

    function automatic void emit_byte(logic [7:0] b);
        out_t r;
        r          = '0;
        r.out_byte = b;
        r.has_byte = 1'b1;
        step_bytes.push_back(r);
    endfunction

    function automatic void release_header();
        logic [7:0] seq[4];
        seq = '{MARKER_PREFIX, hdr_code, hdr_len_hi, hdr_len_lo};
        for (int i = 0; i < hdr_count; i++) emit_byte(seq[i]);
        hdr_count = '0;
    endfunction

    function automatic void restart_parser();
        strip_phase = PH_SOI0;
        hdr_code    = '0;
        hdr_len_hi  = '0;
        hdr_len_lo  = '0;
        hdr_count   = '0;
        skip_left   = '0;
        skip_drop   = 1'b0;
    endfunction

    function automatic void segment_byte(logic [7:0] b);
        if (skip_left != 0) begin
            skip_left = skip_left - 16'd1;
            if (!skip_drop) emit_byte(b);
        end else if (b == MARKER_PREFIX) begin
            hdr_count   = 3'd1;
            strip_phase = PH_MARK;
        end else begin
            emit_byte(b);
            strip_phase = PH_PASS;
        end
    endfunction

    function automatic void strip_predict(in_t it);
        logic [7:0]  b;
        logic [15:0] seg_len;
        b = it.in_byte;
        step_bytes.delete();
        case (strip_phase)
            PH_SOI0: begin
                if (b == MARKER_PREFIX) begin
                    hdr_count   = 3'd1;
                    strip_phase = PH_SOI1;
                end else begin
                    emit_byte(b);
                    strip_phase = PH_PASS;
                end
            end
            PH_SOI1: begin
                release_header();
                emit_byte(b);
                if (b == SOI_CODE) begin
                    strip_phase = PH_BODY;
                    skip_left   = '0;
                    skip_drop   = 1'b0;
                end else begin
                    strip_phase = PH_PASS;
                end
            end
            PH_BODY: segment_byte(b);
            PH_MARK: begin
                if (b >= APP0_CODE && b <= APP15_CODE) begin
                    hdr_code    = b;
                    hdr_count   = 3'd2;
                    strip_phase = PH_LENH;
                end else begin
                    release_header();
                    emit_byte(b);
                    strip_phase = PH_PASS;
                end
            end
            PH_LENH: begin
                hdr_len_hi  = b;
                hdr_count   = 3'd3;
                strip_phase = PH_LENL;
            end
            PH_LENL: begin
                hdr_len_lo = b;
                hdr_count  = 3'd4;
                seg_len    = {hdr_len_hi, hdr_len_lo};
                if (seg_len < 16'd2) begin
                    release_header();
                    strip_phase = PH_PASS;
                end else begin
                    strip_phase = PH_DECIDE;
                end
            end
            PH_DECIDE: begin
                seg_len = {hdr_len_hi, hdr_len_lo};
                if (hdr_code == APP0_CODE) begin
                    release_header();
                    skip_drop = 1'b0;
                end else begin
                    hdr_count = '0;
                    skip_drop = 1'b1;
                end
                skip_left   = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                strip_phase = PH_BODY;
                segment_byte(b);
            end
            default: emit_byte(b);
        endcase
        if (it.end_flag) begin
            release_header();
            if (step_bytes.size() == 0) step_bytes.push_back('0);
            step_bytes[$].stream_done = 1'b1;
            restart_parser();
        end
        if (step_bytes.size() > 0) step_bytes[$].run_last = 1'b1;
        foreach (step_bytes[i]) awaited_bytes.push_back(step_bytes[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int   gap;
        in_t  it;
        gap = 0;
        while (tx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.in_byte = b;
        it.end_flag = last;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        strip_predict(it);
        bytes_sent++;
    endtask

    task automatic send_stream();
        foreach (stream_buf[i]) send_byte(stream_buf[i], i == stream_buf.size() - 1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_bytes.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic push_random_bytes(input int n);
        repeat (n) stream_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_stream();
        int kind;
        int seg_len;
        int code;
        int r;
        stream_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            // noise, sometimes with a lone marker prefix up front
            push_random_bytes($urandom_range(1, 6));
            if ($urandom_range(0, 1)) stream_buf[0] = MARKER_PREFIX;
        end else begin
            stream_buf = '{MARKER_PREFIX, SOI_CODE};
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 3) == 0) code = APP0_CODE;
                else code = $urandom_range(APP1_CODE, APP15_CODE);
                r = $urandom_range(0, 99);
                if (r < 6) seg_len = $urandom_range(0, 1);
                else if (r < 10) seg_len = $urandom_range(256, 300);
                else seg_len = $urandom_range(2, 7);
                stream_buf.push_back(MARKER_PREFIX);
                stream_buf.push_back(8'(code));
                stream_buf.push_back(8'(seg_len >> 8));
                stream_buf.push_back(8'(seg_len));
                if (seg_len >= 2) push_random_bytes(seg_len - 2);
            end
            case ($urandom_range(0, 3))
                0, 1: begin
                    do code = $urandom_range(0, 255);
                    while (code >= APP0_CODE && code <= APP15_CODE);
                    stream_buf.push_back(MARKER_PREFIX);
                    stream_buf.push_back(8'(code));
                    push_random_bytes($urandom_range(0, 4));
                end
                2: begin
                    stream_buf.push_back(8'($urandom_range(0, 254)));
                    push_random_bytes($urandom_range(0, 4));
                end
                default: ;
            endcase
            if (kind < 20)
                stream_buf[$urandom_range(0, stream_buf.size() - 1)] =
                    8'($urandom_range(0, 255));
        end
        if (stream_buf.size() > 1 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, stream_buf.size() - 1)) void'(stream_buf.pop_back());
    endtask

    task automatic test_no_start_marker();
        stream_buf = '{MARKER_PREFIX, 8'h41};
        send_stream();
    endtask

    task automatic test_app_removal();
        stream_buf = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP0_CODE, 8'h00, 8'h03, 8'hAA,
                       MARKER_PREFIX, APP1_CODE, 8'h00, 8'h02,
                       MARKER_PREFIX, DHT_CODE, 8'h7E};
        send_stream();
    endtask

    task automatic test_short_length();
        stream_buf = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP0_CODE, 8'h00, 8'h01};
        send_stream();
    endtask

    task automatic test_cut_header();
        stream_buf = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP1_CODE, 8'h00, 8'h05};
        send_stream();
    endtask

    // longest length, payload cut short; last item is dropped, so end-only
    task automatic test_truncated_payload();
        stream_buf = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP15_CODE,
                       8'hFF, 8'hFF, 8'h00};
        send_stream();
    endtask

    task automatic test_backpressure();
        stream_buf = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP0_CODE, 8'h00, 8'h22};
        push_random_bytes(32);
        stream_buf.push_back(MARKER_PREFIX);
        stream_buf.push_back(SOS_CODE);
        push_random_bytes(8);
        hold_request = 1'b1;
        send_stream();
        wait_drained();
        build_random_stream();
        send_stream();
    endtask

    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (5) begin
            build_random_stream();
            send_stream();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random_streams();
        int target;
        target = ITEM_COUNT;
        while (bytes_sent < target) begin
            build_random_stream();
            send_stream();
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_bytes.size() == 0) begin
                $error("unexpected result item %h", m_item);
                fail_count++;
            end else begin
                want = awaited_bytes.pop_front();
                check_field("out_byte", int'(want.out_byte), int'(m_item.out_byte));
                check_field("has_byte", int'(want.has_byte), int'(m_item.has_byte));
                check_field("stream_done", int'(want.stream_done),
                            int'(m_item.stream_done));
                check_field("run_last", int'(want.run_last), int'(m_item.run_last));
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_start_marker();
        test_app_removal();
        test_short_length();
        test_cut_header();
        test_truncated_payload();
        wait_drained();
        test_backpressure();
        test_full_rate();
        test_random_streams();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
